// File: rtl/matrix3_inverse_unit_assert.svh
// ----------------------------------------------------------------------------
// matrix3_inverse_unit_assert.svh
// assertion macros shared by the matrix inverse block
// ----------------------------------------------------------------------------
`ifndef MATRIX3_INVERSE_UNIT_ASSERT_SVH
`define MATRIX3_INVERSE_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define M3I_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define M3I_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/m3i_pkg.sv
// ----------------------------------------------------------------------------
// m3i_pkg
// shared constants and types of the 3x3 matrix inverse block
// ----------------------------------------------------------------------------
package m3i_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   // adjugate entry k = m[p]*m[q] - m[r]*m[s], row-major entry numbers
   localparam logic [3:0] ADJ_IX [9][4] = '{
      '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
      '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
      '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
   };

   // sign and saturation flags of one divider lane
   typedef struct packed {
      logic neg;
      logic sat;
   } m3i_flag_type;

endpackage

// File: rtl/m3i_req_if.sv
// ----------------------------------------------------------------------------
// m3i_req_if
// input channel: one 3x3 matrix per transfer
// ----------------------------------------------------------------------------
interface m3i_req_if import m3i_pkg::*; #(
   parameter int W = DATA_WIDTH_DEF
) ();
   logic         valid;
   logic         ready;
   logic signed [W-1:0] a11, a12, a13, a21, a22, a23, a31, a32, a33;

   modport source (
      output valid, a11, a12, a13, a21, a22, a23, a31, a32, a33,
      input  ready
   );
   modport sink (
      input  valid, a11, a12, a13, a21, a22, a23, a31, a32, a33,
      output ready
   );
endinterface

// File: rtl/m3i_rsp_if.sv
// ----------------------------------------------------------------------------
// m3i_rsp_if
// result channel: inverse, determinant and singular flag per transfer
// ----------------------------------------------------------------------------
interface m3i_rsp_if import m3i_pkg::*; #(
   parameter int W = DATA_WIDTH_DEF
) ();
   logic         valid;
   logic         ready;
   logic signed [W-1:0] b11, b12, b13, b21, b22, b23, b31, b32, b33;
   logic signed [W-1:0] determinant;
   logic         singular;

   modport source (
      output valid, b11, b12, b13, b21, b22, b23, b31, b32, b33, determinant,
             singular,
      input  ready
   );
   modport sink (
      input  valid, b11, b12, b13, b21, b22, b23, b31, b32, b33, determinant,
             singular,
      output ready
   );
endinterface

// File: rtl/m3i_div_lane.sv
// ----------------------------------------------------------------------------
// m3i_div_lane
// pipelined restoring divider, one quotient bit per stage, with saturation
// ----------------------------------------------------------------------------
module m3i_div_lane import m3i_pkg::*; #(
   parameter int W    = DATA_WIDTH_DEF,
   parameter int NW   = 4 * DATA_WIDTH_DEF,
   parameter int DENW = 4 * DATA_WIDTH_DEF
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0]   num,
   input  logic [DENW-1:0] den,
   input  logic          neg,
   output logic [W-2:0]  quo,
   output m3i_flag_type  flags
);
   localparam int XW = (NW > DENW + W) ? NW : DENW + W;

   logic [NW-1:0]   rem_ff  [W];
   logic [DENW-1:0] den_ff  [W];
   logic [W-2:0]    quo_ff  [W];
   m3i_flag_type    flag_ff [W];

   // first stage only checks for a quotient at or beyond 2^(W-1)
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]      <= num;
         den_ff[0]      <= den;
         quo_ff[0]      <= '0;
         flag_ff[0].neg <= neg;
         flag_ff[0].sat <= (XW'(num) >= (XW'(den) << (W - 1)));
      end
   end

   for (genvar s = 1; s < W; s++) begin : g_stage
      localparam int I = W - 1 - s;
      logic [XW-1:0] rx, dx, diff;
      logic          ge;
      logic [NW-1:0] rem_in;
      logic [W-2:0]  quo_in;

      always_comb begin
         rx     = XW'(rem_ff[s-1]);
         dx     = XW'(den_ff[s-1]) << I;
         diff   = rx - dx;
         ge     = (rx >= dx);
         rem_in = ge ? diff[NW-1:0] : rem_ff[s-1];
         quo_in = quo_ff[s-1];
         quo_in[I] = ge;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            den_ff[s]  <= den_ff[s-1];
            quo_ff[s]  <= quo_in;
            flag_ff[s] <= flag_ff[s-1];
         end
      end
   end

   assign quo   = quo_ff[W-1];
   assign flags = flag_ff[W-1];

endmodule

// File: rtl/matrix3_inverse_unit.sv
// ----------------------------------------------------------------------------
// matrix3_inverse_unit
// pipelined 3x3 fixed-point matrix inverse by adjugate over determinant
// ----------------------------------------------------------------------------
//   channel   dir   payload                                  transfer
//   req_chan  in    a11 .. a33 signed Q(W-F).F                valid & ready
//   rsp_chan  out   b11 .. b33, determinant, singular         valid & ready
//
// one matrix per cycle while the output is not stalled; the pipeline is made of
//   six front stages, DATA_WIDTH divider stages (a saturation check, then one
//   per quotient bit) and the output reg
// reset is synchronous and clears only the stage valid bits
// a stall at the output freezes every stage at once; req_chan.ready is low
//   only while a finished result waits and rsp_chan.ready is low
// ----------------------------------------------------------------------------
`include "matrix3_inverse_unit_assert.svh"

module matrix3_inverse_unit import m3i_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   m3i_req_if.sink   req_chan,
   m3i_rsp_if.source rsp_chan
);
   localparam int W    = DATA_WIDTH;
   localparam int F    = FRAC_BITS;
   localparam int PW   = 2 * W;             // product of two entries
   localparam int CFW  = 2 * W + 1;         // cofactor
   localparam int DTW  = 3 * W + 2;         // determinant
   localparam int NA   = 2 * W + 2 * F + 2;
   localparam int NW   = ((NA > DTW) ? NA : DTW) + 1;  // rounded numerator
   localparam int DENW = DTW + 1;           // twice the determinant magnitude
   localparam int NSTG = W + 7;             // front, divider, output

   // ---- stage valid bits and global advance
   logic [NSTG-1:0] v_ff, v_in;
   logic            adv;

   assign adv            = !v_ff[NSTG-1] || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign v_in           = {v_ff[NSTG-2:0], req_chan.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= v_in;
      end
   end

   // ---- input matrix, row-major
   logic signed [W-1:0] a_in [9];
   assign a_in[0] = req_chan.a11;
   assign a_in[1] = req_chan.a12;
   assign a_in[2] = req_chan.a13;
   assign a_in[3] = req_chan.a21;
   assign a_in[4] = req_chan.a22;
   assign a_in[5] = req_chan.a23;
   assign a_in[6] = req_chan.a31;
   assign a_in[7] = req_chan.a32;
   assign a_in[8] = req_chan.a33;

   // ---- stage 1: the eighteen 2x2 minor products
   logic signed [PW-1:0] prod_ff [9][2];
   logic signed [W-1:0]  row1_ff [3];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 9; k++) begin
            prod_ff[k][0] <= a_in[ADJ_IX[k][0]] * a_in[ADJ_IX[k][1]];
            prod_ff[k][1] <= a_in[ADJ_IX[k][2]] * a_in[ADJ_IX[k][3]];
         end
         for (int j = 0; j < 3; j++) begin
            row1_ff[j] <= a_in[j];
         end
      end
   end

   // ---- stage 2: adjugate entries, exact
   logic signed [CFW-1:0] cof2_ff [9];
   logic signed [W-1:0]   row2_ff [3];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 9; k++) begin
            cof2_ff[k] <= CFW'(prod_ff[k][0]) - CFW'(prod_ff[k][1]);
         end
         row2_ff <= row1_ff;
      end
   end

   // ---- stage 3: first row times first adjugate column, split in halves
   // adjugate entries 0, 3 and 6 are the first-row cofactors
   logic signed [2*W:0]   lo_ff   [3];
   logic signed [2*W:0]   hi_ff   [3];
   logic signed [CFW-1:0] cof3_ff [9];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 3; j++) begin
            lo_ff[j] <= row2_ff[j] * $signed({1'b0, cof2_ff[3*j][W-1:0]});
            hi_ff[j] <= row2_ff[j] * $signed(cof2_ff[3*j][CFW-1:W]);
         end
         cof3_ff <= cof2_ff;
      end
   end

   // ---- stage 4: determinant, same value as the six-term rule
   logic signed [DTW-1:0] det_in, det4_ff;
   logic signed [CFW-1:0] cof4_ff [9];

   always_comb begin
      det_in = '0;
      for (int j = 0; j < 3; j++) begin
         det_in = det_in + (DTW'(hi_ff[j]) << W) + DTW'(lo_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         det4_ff <= det_in;
         cof4_ff <= cof3_ff;
      end
   end

   // ---- stage 5: signs and magnitudes
   logic                 dneg5_ff, dzero5_ff;
   logic [DTW-1:0]       dmag5_ff;
   logic [8:0]           cneg5_ff;
   logic [CFW-1:0]       cmag5_ff [9];

   always_ff @(posedge clock) begin
      if (adv) begin
         dneg5_ff  <= det4_ff[DTW-1];
         dzero5_ff <= (det4_ff == '0);
         dmag5_ff  <= det4_ff[DTW-1] ? DTW'(-det4_ff) : DTW'(det4_ff);
         for (int k = 0; k < 9; k++) begin
            cneg5_ff[k] <= cof4_ff[k][CFW-1];
            cmag5_ff[k] <= cof4_ff[k][CFW-1] ? CFW'(-cof4_ff[k]) : CFW'(cof4_ff[k]);
         end
      end
   end

   // ---- stage 6: rounded numerators, divisor, determinant output
   // quotient (c * 2^(2F+1) + d) / (2d) is c * 2^(2F) / d rounded half away
   logic [DTW:0]        rsum, rsh;
   logic                rsat;
   logic signed [W-1:0] dout_in;

   always_comb begin
      rsum = (DTW+1)'(dmag5_ff) + ((DTW+1)'(1) << (2 * F - 1));
      rsh  = rsum >> (2 * F);
      rsat = |rsh[DTW:W-1];
      if (rsat) begin
         dout_in = dneg5_ff ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
         dout_in = dneg5_ff ? -$signed(rsh[W-1:0]) : $signed(rsh[W-1:0]);
      end
   end

   logic [NW-1:0]       num6_ff [9];
   logic [DENW-1:0]     den6_ff;
   logic [8:0]          ineg6_ff;
   logic signed [W-1:0] dout6_ff;
   logic                sing6_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 9; k++) begin
            num6_ff[k]  <= (NW'(cmag5_ff[k]) << (2 * F + 1)) + NW'(dmag5_ff);
            ineg6_ff[k] <= cneg5_ff[k] ^ dneg5_ff;
         end
         den6_ff  <= DENW'(dmag5_ff) << 1;
         dout6_ff <= dout_in;
         sing6_ff <= dzero5_ff;
      end
   end

   // ---- divider lanes, one per inverse entry
   logic [W-2:0] quo   [9];
   m3i_flag_type flags [9];

   for (genvar k = 0; k < 9; k++) begin : g_div
      m3i_div_lane #(
         .W    (W),
         .NW   (NW),
         .DENW (DENW)
      ) u_div (
         .clock (clock),
         .en    (adv),
         .num   (num6_ff[k]),
         .den   (den6_ff),
         .neg   (ineg6_ff[k]),
         .quo   (quo[k]),
         .flags (flags[k])
      );
   end

   // determinant and singular flag ride alongside the divider stages
   logic signed [W-1:0] dside_ff [W];
   logic                sside_ff [W];

   always_ff @(posedge clock) begin
      if (adv) begin
         dside_ff[0] <= dout6_ff;
         sside_ff[0] <= sing6_ff;
         for (int s = 1; s < W; s++) begin
            dside_ff[s] <= dside_ff[s-1];
            sside_ff[s] <= sside_ff[s-1];
         end
      end
   end

   // ---- output register: sign, saturation, singular override
   logic signed [W-1:0] bout_in [9];
   logic signed [W-1:0] bout_ff [9];
   logic signed [W-1:0] dtout_ff;
   logic                sgout_ff;

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         if (sside_ff[W-1]) begin
            bout_in[k] = '0;
         end else if (flags[k].sat) begin
            bout_in[k] = flags[k].neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
         end else begin
            bout_in[k] = flags[k].neg ? -$signed({1'b0, quo[k]}) : $signed({1'b0, quo[k]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         bout_ff  <= bout_in;
         dtout_ff <= sside_ff[W-1] ? '0 : dside_ff[W-1];
         sgout_ff <= sside_ff[W-1];
      end
   end

   assign rsp_chan.valid       = v_ff[NSTG-1];
   assign rsp_chan.b11         = bout_ff[0];
   assign rsp_chan.b12         = bout_ff[1];
   assign rsp_chan.b13         = bout_ff[2];
   assign rsp_chan.b21         = bout_ff[3];
   assign rsp_chan.b22         = bout_ff[4];
   assign rsp_chan.b23         = bout_ff[5];
   assign rsp_chan.b31         = bout_ff[6];
   assign rsp_chan.b32         = bout_ff[7];
   assign rsp_chan.b33         = bout_ff[8];
   assign rsp_chan.determinant = dtout_ff;
   assign rsp_chan.singular    = sgout_ff;

   // ---- assertions
   `M3I_ASSERT_IMP(a_singular_zero, clock, reset,
      rsp_chan.valid && rsp_chan.singular,
      rsp_chan.determinant == '0 && rsp_chan.b11 == '0 && rsp_chan.b33 == '0,
      "singular result carries nonzero fields")
   `M3I_ASSERT_NXT(a_accept_enters, clock, reset,
      req_chan.valid && req_chan.ready, v_ff[0],
      "accepted matrix did not enter the first stage")
   `M3I_ASSERT_NXT(a_stall_freezes, clock, reset,
      !adv, $stable(v_ff), "pipeline moved during a stall")

endmodule

// File: tb/matrix3_inverse_checker.sv
// ----------------------------------------------------------------------------
// matrix3_inverse_checker
// watches both channels, computes the expected rounded inverse of every accepted matrix
// and compares it field by field with the block's result, in order
// ----------------------------------------------------------------------------
module matrix3_inverse_checker import m3i_pkg::*; #(
   parameter int W = 32,
   parameter int F = 16
) (
   input  logic      clock,
   input  logic      reset,
   m3i_req_if.sink   req_mon,
   m3i_rsp_if.sink   rsp_mon,
   output int        fail_count,
   output int        pending_count
);

   typedef logic signed [W-1:0] word_type;
   typedef logic signed [255:0] wide_type;

   typedef struct {
      word_type b [9];
      word_type det;
      logic     singular;
   } inverse_type;

   inverse_type expected_inverses [$];

   // saturate a magnitude with sign to the word range
   function automatic word_type clamp_word(logic neg, wide_type mag);
      wide_type lim;
      lim = wide_type'(1) <<< (W - 1);
      if (neg) begin
         if (mag > lim) mag = lim;
         return word_type'(-mag);
      end
      if (mag >= lim) mag = lim - 1;
      return word_type'(mag);
   endfunction

   function automatic inverse_type compute_inverse(word_type a [9]);
      inverse_type r;
      wide_type m [9];
      wide_type det, dmag, cof, cmag, num;
      logic dneg, cneg;
      for (int k = 0; k < 9; k++) m[k] = a[k];
      det = m[0]*m[4]*m[8] + m[3]*m[7]*m[2] + m[6]*m[1]*m[5]
          - m[0]*m[7]*m[5] - m[6]*m[4]*m[2] - m[3]*m[1]*m[8];
      if (det == 0) begin
         foreach (r.b[k]) r.b[k] = '0;
         r.det = '0;
         r.singular = 1'b1;
         return r;
      end
      dneg = det < 0;
      dmag = dneg ? -det : det;
      r.det = clamp_word(dneg, (dmag + (wide_type'(1) <<< (2*F - 1))) >>> (2*F));
      for (int k = 0; k < 9; k++) begin
         cof = m[ADJ_IX[k][0]] * m[ADJ_IX[k][1]] - m[ADJ_IX[k][2]] * m[ADJ_IX[k][3]];
         cneg = cof < 0;
         cmag = cneg ? -cof : cof;
         // rounded to nearest: (2c*2^2F + d) / 2d
         num = (cmag <<< (2*F + 1)) + dmag;
         r.b[k] = clamp_word(cneg != dneg, num / (dmag <<< 1));
      end
      r.singular = 1'b0;
      return r;
   endfunction

   task automatic compare_field(string name, word_type want, word_type got);
      if (want !== got) begin
         $error("%s expected %0d got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      word_type a [9];
      word_type got [9];
      inverse_type want;
      if (reset) begin
         fail_count = 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            a = '{req_mon.a11, req_mon.a12, req_mon.a13, req_mon.a21, req_mon.a22,
                  req_mon.a23, req_mon.a31, req_mon.a32, req_mon.a33};
            expected_inverses.push_back(compute_inverse(a));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_inverses.size() == 0) begin
               $error("result transfer with nothing expected");
               fail_count++;
            end else begin
               want = expected_inverses.pop_front();
               got = '{rsp_mon.b11, rsp_mon.b12, rsp_mon.b13, rsp_mon.b21,
                       rsp_mon.b22, rsp_mon.b23, rsp_mon.b31, rsp_mon.b32,
                       rsp_mon.b33};
               for (int k = 0; k < 9; k++)
                  compare_field($sformatf("b%0d%0d", k/3 + 1, k%3 + 1), want.b[k], got[k]);
               compare_field("determinant", want.det, rsp_mon.determinant);
               if (want.singular !== rsp_mon.singular) begin
                  $error("singular expected %0d got %0d", want.singular, rsp_mon.singular);
                  fail_count++;
               end
            end
         end
      end
      pending_count = expected_inverses.size();
   end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// stimulus for the 3x3 matrix inverse block: directed corner matrices, then
// random, singular and near-singular ones, with random gaps on both sides
// ----------------------------------------------------------------------------
module tb import m3i_pkg::*; ();

   localparam int W = DATA_WIDTH_DEF;
   localparam int F = FRAC_BITS_DEF;
   localparam int LATENCY = W + 7;
   localparam int NUM_RANDOM = 1730;
   localparam int STALL_LIMIT = 4000;

   typedef logic signed [W-1:0] word_type;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   idle_cycles;
   int   rsp_wait;

   m3i_req_if #(.W(W)) req_chan ();
   m3i_rsp_if #(.W(W)) rsp_chan ();

   matrix3_inverse_unit #(.DATA_WIDTH(W), .FRAC_BITS(F)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   matrix3_inverse_checker #(.W(W), .F(F)) checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan.sink),
      .rsp_mon       (rsp_chan.sink),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // one fixed-point value: mostly moderate, sometimes full range or exact
   function automatic word_type random_entry();
      case ($urandom_range(0, 5))
         0:       return word_type'($urandom);
         1:       return word_type'($signed($urandom_range(0, 8)) - 4) <<< F;
         2:       return word_type'($signed($urandom_range(0, 2000)) - 1000);
         default: return word_type'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      endcase
   endfunction

   // hand one matrix over, after a random gap, and wait for its transfer
   task automatic send_matrix(word_type a [9]);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      {req_chan.a11, req_chan.a12, req_chan.a13, req_chan.a21, req_chan.a22,
       req_chan.a23, req_chan.a31, req_chan.a32, req_chan.a33} <=
         {a[0], a[1], a[2], a[3], a[4], a[5], a[6], a[7], a[8]};
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // result side: random stall per transfer, bursts without stalls too
   initial begin
      rsp_chan.ready <= 1'b0;
      @(negedge reset);
      forever begin
         rsp_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         if (rsp_wait > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (rsp_wait) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   // watchdog on cycles with no transfer at all
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      word_type a [9];
      word_type one, maxv, minv;
      one  = word_type'(1) <<< F;
      maxv = {1'b0, {(W-1){1'b1}}};
      minv = {1'b1, {(W-1){1'b0}}};
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      {req_chan.a11, req_chan.a12, req_chan.a13, req_chan.a21, req_chan.a22,
       req_chan.a23, req_chan.a31, req_chan.a32, req_chan.a33} <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // identity, scaled identity, negated identity
      send_matrix('{one, 0, 0, 0, one, 0, 0, 0, one});
      send_matrix('{2*one, 0, 0, 0, 4*one, 0, 0, 0, -8*one});
      send_matrix('{-one, 0, 0, 0, -one, 0, 0, 0, -one});
      // all zero and rank-deficient rows: singular
      send_matrix('{0, 0, 0, 0, 0, 0, 0, 0, 0});
      send_matrix('{one, 2*one, 3*one, 4*one, 5*one, 6*one, 7*one, 8*one, 9*one});
      send_matrix('{maxv, maxv, maxv, maxv, maxv, maxv, maxv, maxv, maxv});
      // extremes on the diagonal: determinant saturates; then extremes off the diagonal
      send_matrix('{maxv, 0, 0, 0, maxv, 0, 0, 0, maxv});
      send_matrix('{minv, 0, 0, 0, minv, 0, 0, 0, minv});
      send_matrix('{minv, 0, 0, 0, maxv, 0, 0, 0, minv});
      send_matrix('{maxv, minv, 0, minv, maxv, 0, 0, 0, one});
      // tiny determinant: rounds to zero, inverse saturates
      send_matrix('{1, 0, 0, 0, 1, 0, 0, 0, 1});
      send_matrix('{-1, 0, 0, 0, 1, 0, 0, 0, 1});
      send_matrix('{256, 0, 0, 0, 256, 0, 0, 0, 1});
      // rounding ties and small values
      send_matrix('{one + (one >>> 1), 0, 0, 0, 3*one, 0, 0, 0, one});
      send_matrix('{2, 1, 0, 1, 2, 1, 0, 1, 2});
      send_matrix('{one, one, 0, 0, one, one, one, 0, one});
      send_matrix('{-1, -1, -1, maxv, 0, minv, 1, minv, maxv});
      send_matrix('{word_type'(32'h5555_5555), word_type'(32'hAAAA_AAAA), 0, 0,
                    word_type'(32'h5555_5555), word_type'(32'hAAAA_AAAA), one, 0, 7});

      for (int n = 0; n < NUM_RANDOM; n++) begin
         foreach (a[k]) a[k] = random_entry();
         case ($urandom_range(0, 9))
            0: begin
               // copy one row onto another: exactly singular
               for (int c = 0; c < 3; c++) a[3 + c] = a[c];
            end
            1: begin
               // diagonal with small values: tiny determinants
               foreach (a[k]) if (k % 4 != 0) a[k] = '0;
               for (int k = 0; k < 9; k += 4) a[k] = $signed($urandom_range(0, 64)) - 32;
            end
            2: foreach (a[k]) a[k] = ($urandom_range(0, 1) == 1) ? maxv : minv;
            default: ;
         endcase
         send_matrix(a);
      end
      req_chan.valid <= 1'b0;

      wait (pending_count == 0);
      repeat (2 * LATENCY) @(posedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
